[hw/rtl/assert_macros.svh]
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Clocked property, disabled while the active-low reset is asserted.
`define CLSR_ASSERT_RST(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked property checked at every edge, reset included.
`define CLSR_ASSERT_CLK(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define CLSR_ASSERT_RST(lbl, clk, rst_n, prop, msg)

`define CLSR_ASSERT_CLK(lbl, clk, prop, msg)

`endif

`endif

[hw/rtl/clsr_pkg.sv]
`timescale 1ns / 1ps

package clsr_pkg;

  localparam int StateW = 31;
  localparam int FracW  = 32;
  localparam int MulW   = 16;
  localparam int FoldW  = 8;

  localparam int TableDepth = 32;
  localparam int SlotW      = $clog2(TableDepth);

  localparam logic [StateW-1:0] ModA = 31'd2147483563;
  localparam logic [StateW-1:0] ModB = 31'd2147483399;
  localparam logic [MulW-1:0]   MulA = 16'd40014;
  localparam logic [MulW-1:0]   MulB = 16'd40692;

  localparam logic [StateW-1:0] FirstReset  = 31'd1;
  localparam logic [StateW-1:0] SecondReset = 31'd123456789;
  localparam logic [StateW-1:0] SeedReset   = 31'd1;

  // 2^31 is congruent to these small values modulo the two moduli.
  localparam logic [FoldW-1:0] FoldA = FoldW'((64'd1 << StateW) - 64'(ModA));
  localparam logic [FoldW-1:0] FoldB = FoldW'((64'd1 << StateW) - 64'(ModB));

  localparam int ProdW = StateW + MulW;

  // Slot index: output divided by SlotDiv through a rounded-up reciprocal.
  localparam longint unsigned SlotDiv =
    64'd1 + (64'(ModA) - 64'd1) / 64'(TableDepth);
  localparam int SlotShift = StateW + $clog2(SlotDiv);
  localparam longint unsigned SlotRecip =
    ((64'd1 << SlotShift) + SlotDiv - 64'd1) / SlotDiv;
  localparam int RecipW    = $clog2(SlotRecip + 64'd1);
  localparam int SlotProdW = StateW + RecipW;
  localparam logic [RecipW-1:0] SlotMul = RecipW'(SlotRecip);

  // Fraction: raw * 2^32 / ModA = 2 * raw + (FracK * raw) / ModA.
  localparam logic [FoldW:0] FracK     = {FoldA, 1'b0};
  localparam int             FracProdW = StateW + FoldW + 1;
  localparam logic [FracW-1:0] FracCap = 32'd4294966780;

  localparam int WarmSteps = TableDepth + 8;
  localparam int WarmCntW  = $clog2(WarmSteps);

  typedef struct packed {
    logic                seed_load;
    logic                gen_mul;
    logic                warm_step;
    logic                gen_step;
    logic                mix;
    logic                frac_mul;
    logic                rsp_load;
    logic [WarmCntW-1:0] warm_idx;
  } clsr_cmd_t;

  typedef struct packed {
    logic rsp_busy;
  } clsr_status_t;

endpackage

[hw/rtl/clsr_if.sv]
`timescale 1ns / 1ps

interface clsr_req_if;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink (input valid, input restart, output ready);
endinterface

interface clsr_rsp_if;
  import clsr_pkg::*;

  logic              valid;
  logic              ready;
  logic [StateW-1:0] raw_value;
  logic [FracW-1:0]  fraction;

  modport source (output valid, output raw_value, output fraction, input ready);
  modport sink (input valid, input raw_value, input fraction, output ready);
endinterface

interface clsr_cfg_if;
  import clsr_pkg::*;

  logic              valid;
  logic              ready;
  logic [StateW-1:0] seed;

  modport source (output valid, output seed, input ready);
  modport sink (input valid, input seed, output ready);
endinterface

[hw/rtl/clsr_ram.sv]
`timescale 1ns / 1ps

module clsr_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[hw/rtl/clsr_ctrl.sv]
`timescale 1ns / 1ps
`include "assert_macros.svh"

module clsr_ctrl (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  clsr_req_if.sink                req_i,
  output clsr_pkg::clsr_cmd_t     cmd_o,
  input  clsr_pkg::clsr_status_t  status_i
);
  import clsr_pkg::*;

  typedef enum logic [8:0] {
    StIdle     = 9'b000000001,
    StSeed     = 9'b000000010,
    StWarmMul  = 9'b000000100,
    StWarmRed  = 9'b000001000,
    StMul      = 9'b000010000,
    StRed      = 9'b000100000,
    StMix      = 9'b001000000,
    StFracMul  = 9'b010000000,
    StOut      = 9'b100000000
  } clsr_state_e;

  clsr_state_e         state_q, state_d;
  logic [WarmCntW-1:0] cnt_q, cnt_d;

  assign req_i.ready = (state_q == StIdle);

  always_comb begin
    state_d        = state_q;
    cnt_d          = cnt_q;
    cmd_o          = '0;
    cmd_o.warm_idx = cnt_q;
    unique case (state_q)
      StIdle: begin
        if (req_i.valid) begin
          state_d = req_i.restart ? StSeed : StMul;
        end
      end
      StSeed: begin
        cmd_o.seed_load = 1'b1;
        cnt_d           = WarmCntW'(WarmSteps - 1);
        state_d         = StWarmMul;
      end
      StWarmMul: begin
        cmd_o.gen_mul = 1'b1;
        state_d       = StWarmRed;
      end
      StWarmRed: begin
        cmd_o.warm_step = 1'b1;
        if (cnt_q == '0) begin
          state_d = StMul;
        end else begin
          cnt_d   = cnt_q - WarmCntW'(1);
          state_d = StWarmMul;
        end
      end
      StMul: begin
        cmd_o.gen_mul = 1'b1;
        state_d       = StRed;
      end
      StRed: begin
        cmd_o.gen_step = 1'b1;
        state_d        = StMix;
      end
      StMix: begin
        cmd_o.mix = 1'b1;
        state_d   = StFracMul;
      end
      StFracMul: begin
        cmd_o.frac_mul = 1'b1;
        state_d        = StOut;
      end
      StOut: begin
        if (!status_i.rsp_busy) begin
          cmd_o.rsp_load = 1'b1;
          state_d        = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  `CLSR_ASSERT_CLK(cmd_quiet_in_reset_a, clk_i, !rst_ni |-> (cmd_o == '0), "command issued in reset")

endmodule

[hw/rtl/clsr_dpath.sv]
`timescale 1ns / 1ps
`include "assert_macros.svh"

module clsr_dpath (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  clsr_pkg::clsr_cmd_t     cmd_i,
  output clsr_pkg::clsr_status_t  status_o,
  clsr_cfg_if.sink                cfg_i,
  clsr_rsp_if.source              rsp_o
);
  import clsr_pkg::*;

  // Reduces a 47-bit product by folding the upper bits with 2^31 mod m.
  function automatic logic [StateW-1:0] fold_mod(input logic [ProdW-1:0]  p,
                                                 input logic [FoldW-1:0]  k,
                                                 input logic [StateW-1:0] m);
    logic [MulW+FoldW-1:0] upper;
    logic [StateW:0]       sum;
    upper = p[ProdW-1:StateW] * k;
    sum   = {1'b0, p[StateW-1:0]} + (StateW + 1)'(upper);
    if (sum >= {1'b0, m}) begin
      fold_mod = StateW'(sum - {1'b0, m});
    end else begin
      fold_mod = sum[StateW-1:0];
    end
  endfunction

  logic [StateW-1:0]     seed_q;
  logic [StateW-1:0]     x1_q, x1_d;
  logic [StateW-1:0]     x2_q, x2_d;
  logic [StateW-1:0]     shuf_q, shuf_d;
  logic [TableDepth-1:0] valid_q, valid_d;
  logic                  rsp_valid_q, rsp_valid_d;

  logic [ProdW-1:0]      prod1_q, prod2_q;
  logic [SlotProdW-1:0]  slot_prod_q;
  logic [FracProdW-1:0]  frac_prod_q;
  logic [StateW-1:0]     rsp_raw_q;
  logic [FracW-1:0]      rsp_frac_q;

  logic [StateW-1:0]     seed_eff;
  logic [StateW-1:0]     red1, red2;
  logic [SlotW-1:0]      slot;
  logic                  warm_wr;
  logic                  ram_we;
  logic [SlotW-1:0]      ram_waddr;
  logic [StateW-1:0]     ram_wdata;
  logic [StateW-1:0]     ram_rdata;
  logic [StateW-1:0]     entry;
  logic [StateW-1:0]     mixed;

  logic [FoldW:0]        frac_hi;
  logic [2*FoldW:0]      frac_fold;
  logic [StateW:0]       frac_low;
  logic                  frac_carry;
  logic [FracW:0]        frac_sum;
  logic [FracW-1:0]      frac_val;

  assign cfg_i.ready = 1'b1;

  assign seed_eff = (seed_q == '0) ? StateW'(1) : seed_q;
  assign red1     = fold_mod(prod1_q, FoldA, ModA);
  assign red2     = fold_mod(prod2_q, FoldB, ModB);
  assign slot     = slot_prod_q[SlotShift +: SlotW];

  assign warm_wr   = cmd_i.warm_step && (cmd_i.warm_idx < WarmCntW'(TableDepth));
  assign ram_we    = warm_wr || cmd_i.mix;
  assign ram_waddr = cmd_i.mix ? slot : cmd_i.warm_idx[SlotW-1:0];
  assign ram_wdata = cmd_i.mix ? x1_q : red1;

  clsr_ram #(
    .Width (StateW),
    .Depth (TableDepth)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (slot),
    .rdata_o (ram_rdata)
  );

  // An entry that was never written reads as zero.
  assign entry = valid_q[slot] ? ram_rdata : '0;

  always_comb begin
    if (entry > x2_q) begin
      mixed = entry - x2_q;
    end else begin
      mixed = ModA - (x2_q - entry) - StateW'(1);
    end
  end

  always_comb begin
    frac_hi    = frac_prod_q[FracProdW-1:StateW];
    frac_fold  = frac_hi * FoldA;
    frac_low   = {1'b0, frac_prod_q[StateW-1:0]} + (StateW + 1)'(frac_fold);
    frac_carry = (frac_low >= {1'b0, ModA});
    frac_sum   = {1'b0, shuf_q, 1'b0} + (FracW + 1)'(frac_hi) + (FracW + 1)'(frac_carry);
    if (frac_sum > {1'b0, FracCap}) begin
      frac_val = FracCap;
    end else begin
      frac_val = frac_sum[FracW-1:0];
    end
  end

  always_comb begin
    x1_d    = x1_q;
    x2_d    = x2_q;
    shuf_d  = shuf_q;
    valid_d = valid_q;
    if (cmd_i.seed_load) begin
      x1_d = seed_eff;
      x2_d = seed_eff;
    end
    if (cmd_i.warm_step) begin
      x1_d = red1;
      if (cmd_i.warm_idx == '0) begin
        shuf_d = red1;
      end
    end
    if (cmd_i.gen_step) begin
      x1_d = red1;
      x2_d = red2;
    end
    if (cmd_i.mix) begin
      shuf_d = mixed;
    end
    if (ram_we) begin
      valid_d[ram_waddr] = 1'b1;
    end
  end

  always_comb begin
    rsp_valid_d = rsp_valid_q;
    if (cmd_i.rsp_load) begin
      rsp_valid_d = 1'b1;
    end else if (rsp_o.ready) begin
      rsp_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q      <= SeedReset;
      x1_q        <= FirstReset;
      x2_q        <= SecondReset;
      shuf_q      <= '0;
      valid_q     <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      if (cfg_i.valid && cfg_i.ready) begin
        seed_q <= cfg_i.seed;
      end
      x1_q        <= x1_d;
      x2_q        <= x2_d;
      shuf_q      <= shuf_d;
      valid_q     <= valid_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.gen_mul) begin
      prod1_q     <= x1_q * MulA;
      prod2_q     <= x2_q * MulB;
      slot_prod_q <= shuf_q * SlotMul;
    end
    if (cmd_i.frac_mul) begin
      frac_prod_q <= shuf_q * FracK;
    end
    if (cmd_i.rsp_load) begin
      rsp_raw_q  <= shuf_q;
      rsp_frac_q <= frac_val;
    end
  end

  assign status_o.rsp_busy = rsp_valid_q && !rsp_o.ready;

  assign rsp_o.valid     = rsp_valid_q;
  assign rsp_o.raw_value = rsp_raw_q;
  assign rsp_o.fraction  = rsp_frac_q;

  `CLSR_ASSERT_RST(cmd_excl_a, clk_i, rst_ni, $onehot0({cmd_i.seed_load, cmd_i.gen_mul, cmd_i.warm_step, cmd_i.gen_step, cmd_i.mix, cmd_i.frac_mul, cmd_i.rsp_load}), "overlapping datapath commands")
  `CLSR_ASSERT_RST(gen_range_a, clk_i, rst_ni, cmd_i.gen_step |=> (x1_q < ModA) && (x2_q < ModB), "generator state not reduced")
  `CLSR_ASSERT_RST(raw_range_a, clk_i, rst_ni, rsp_o.valid |-> (rsp_o.raw_value != '0) && (rsp_o.raw_value < ModA), "raw value out of range")
  `CLSR_ASSERT_RST(frac_cap_a, clk_i, rst_ni, rsp_o.valid |-> (rsp_o.fraction <= FracCap), "fraction above cap")

endmodule

[hw/rtl/combined_lcg_shuffled_random.sv]
// A beat without restart runs multiply, fold and reduce, mix, fraction multiply
// and output. A beat with restart first takes one seed load and 40 warm-up steps,
// each a multiply, then fold and reduce; the last 32 of them fill the table.
// No new beat is taken until the last result is loaded, which waits for ready.
// Reset (asynchronous, active low): seed 1, generators 1 and 123456789,
// previous output 0, and every table entry reads as zero until written.
`timescale 1ns / 1ps

module combined_lcg_shuffled_random (
  input  logic        clk_i,
  input  logic        rst_ni,
  clsr_req_if.sink    req_i,
  clsr_rsp_if.source  rsp_o,
  clsr_cfg_if.sink    cfg_i
);
  import clsr_pkg::*;

  clsr_cmd_t    cmd;
  clsr_status_t status;

  clsr_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (req_i),
    .cmd_o    (cmd),
    .status_i (status)
  );

  clsr_dpath u_dpath (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd),
    .status_o (status),
    .cfg_i    (cfg_i),
    .rsp_o    (rsp_o)
  );

endmodule
